// ----- hw/rtl/distance_vector_table_update_assert.svh -----
// assertion macros shared by the route table rtl
`ifndef DISTANCE_VECTOR_TABLE_UPDATE_ASSERT_SVH
`define DISTANCE_VECTOR_TABLE_UPDATE_ASSERT_SVH

// condition must hold in the same cycle
`define DVTU_ASSERT_NOW(lbl, cond, chk) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (chk)) \
    else $error("route table check failed");

// condition must hold in the next cycle
`define DVTU_ASSERT_NEXT(lbl, cond, chk) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (chk)) \
    else $error("route table check failed");

`endif

// ----- hw/rtl/dvtu_pkg.sv -----
`default_nettype none

package dvtu_pkg;

  localparam int COST_W = 16;
  localparam int HOP_W  = 4;
  localparam int IDX_W  = 3;
  localparam int KIND_W = 2;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADV  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DOWN = 2'd2;

  // register index, taken from the word address bit
  localparam logic REG_SELF_INDEX = 1'b0;

  localparam logic [COST_W-1:0] COST_UNREACH = 16'hFFFF;
  localparam logic [COST_W-1:0] COST_MAX     = 16'h7FFF;
  localparam logic [HOP_W-1:0]  HOP_NONE     = 4'd8;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [HOP_W-1:0]  hop;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{cost: COST_UNREACH, hop: HOP_NONE};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_LAST
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dvtu_ram.sv -----
`default_nettype none

// one write port, two registered read ports
module dvtu_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/distance_vector_table_update.sv -----
// channel   | direction | handshake                   | payload
// input     | in        | start high, busy low        | in_kind/neighbor/dest/cost/last
// result    | out       | out_valid strobe, one beat  | out_entry_*, out_table_changed
// config    | in/out    | apb write, pready tied high | pwdata[2:0] = self_index at byte 0
//
// an item passes through a read state for the route memories, then an execute state that executes and writes back.
// the last advertisement element with dest differing from neighbor adds a last state for the second write,
// since the live memory has one write port and two entries are updated.
// the result beat appears in the cycle after the final write and cannot be stalled.
// reset is synchronous; entries read as unreachable through per-entry flags, no clearing pass.
// a link-down item restores the live table by marking every entry as mirrored from backup.
`default_nettype none

`include "distance_vector_table_update_assert.svh"

module distance_vector_table_update #(
  parameter int NODES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input beat
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [2:0]  in_neighbor,
  input  wire logic [2:0]  in_dest,
  input  wire logic signed [15:0] in_cost,
  input  wire logic        in_last,
  // result beat
  output logic             out_valid,
  output logic [2:0]       out_entry_dest,
  output logic signed [15:0] out_entry_cost,
  output logic [3:0]       out_entry_next_hop,
  output logic             out_entry_changed,
  output logic             out_table_changed,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = $clog2(NODES);
  localparam logic [6:0] NODES_W = 7'(NODES);

  dvtu_pkg::state_t state_r, state_nxt;

  // item registers
  logic [1:0]  kind_r;
  logic [2:0]  nb_r;
  logic [2:0]  dest_r;
  logic [15:0] cost_r;
  logic        last_r;

  logic [2:0]  self_r;

  // per-entry flags
  logic [NODES-1:0] live_valid_r, live_valid_nxt;
  logic [NODES-1:0] bk_valid_r, bk_valid_nxt;
  logic [NODES-1:0] alias_r, alias_nxt;
  logic [NODES-1:0] bk_init_r, bk_init_nxt;

  logic [15:0] pend_r, pend_nxt;
  logic        change_r, change_nxt;

  // second write of a last element
  logic [AW-1:0]        last_addr_r;
  dvtu_pkg::entry_t     last_word_r;

  // result registers
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_dest_r, out_dest_nxt;
  logic [15:0] out_cost_r, out_cost_nxt;
  logic [3:0]  out_hop_r, out_hop_nxt;
  logic        out_ec_r, out_ec_nxt;
  logic        out_tc_r, out_tc_nxt;

  logic accept;
  logic need_last;
  logic cfg_wr;

  // memory ports
  logic             live_we;
  logic [AW-1:0]    live_waddr;
  dvtu_pkg::entry_t live_wdata;
  logic             bk_we;
  dvtu_pkg::entry_t bk_wdata;
  dvtu_pkg::entry_t lv_a_q, lv_b_q, bk_a_q, bk_b_q;

  // datapath
  logic [AW-1:0]    dest_a, nb_a;
  logic             nb_ok, dest_ok;
  dvtu_pkg::entry_t bk_d, bk_n, lv_d, lv_n;
  dvtu_pkg::entry_t dest_word;
  logic             returning;
  logic             lvalid_nb, lvalid_d;
  logic [15:0]      orig, hopc, sum, sat;
  logic             is_self, can, better, tie, upd;
  logic [15:0]      relaxed_cost, pend_new;
  logic [3:0]       hop_new;
  logic             change_new;

  assign dest_a = AW'(dest_r);
  assign nb_a   = AW'(nb_r);
  assign nb_ok  = {4'b0, nb_r} < NODES_W;
  assign dest_ok = {4'b0, dest_r} < NODES_W;
  assign accept = start && !busy;

  // direct link word for the backup table
  assign bk_wdata.cost = cost_r;
  assign bk_wdata.hop  = {1'b0, nb_r};

  // route memories
  dvtu_ram #(.WIDTH($bits(dvtu_pkg::entry_t)), .DEPTH(NODES)) u_live_ram (
    .clk     (clk),
    .we      (live_we),
    .waddr   (live_waddr),
    .wdata   (live_wdata),
    .raddr_a (dest_a),
    .raddr_b (nb_a),
    .rdata_a (lv_a_q),
    .rdata_b (lv_b_q)
  );

  dvtu_ram #(.WIDTH($bits(dvtu_pkg::entry_t)), .DEPTH(NODES)) u_bk_ram (
    .clk     (clk),
    .we      (bk_we),
    .waddr   (nb_a),
    .wdata   (bk_wdata),
    .raddr_a (dest_a),
    .raddr_b (nb_a),
    .rdata_a (bk_a_q),
    .rdata_b (bk_b_q)
  );

  // raw entries as seen through reset and mirror flags
  always_comb begin
    bk_d = bk_init_r[dest_a] ? bk_a_q : dvtu_pkg::ENTRY_RESET;
    bk_n = bk_init_r[nb_a]   ? bk_b_q : dvtu_pkg::ENTRY_RESET;
    lv_d = alias_r[dest_a] ? bk_d : lv_a_q;
    lv_n = alias_r[nb_a]   ? bk_n : lv_b_q;
  end

  // relaxation of one advertisement element
  always_comb begin
    returning = !bk_valid_r[nb_a];
    lvalid_nb = live_valid_r[nb_a] || returning;
    lvalid_d  = (dest_r == nb_r) ? lvalid_nb : live_valid_r[dest_a];
    orig      = lvalid_d  ? lv_d.cost : dvtu_pkg::COST_UNREACH;
    hopc      = lvalid_nb ? lv_n.cost : dvtu_pkg::COST_UNREACH;
    is_self   = dest_r == self_r;
    sum       = hopc + cost_r;
    sat       = sum[15] ? dvtu_pkg::COST_MAX : sum;
    can       = !is_self && hopc != dvtu_pkg::COST_UNREACH &&
                cost_r != dvtu_pkg::COST_UNREACH;
    better    = can && (orig == dvtu_pkg::COST_UNREACH || sat < orig);
    tie       = can && orig != dvtu_pkg::COST_UNREACH && sat == orig;
    upd       = better || (tie && lv_d.hop > {1'b0, nb_r});
    relaxed_cost = (better || tie) ? sat : lv_d.cost;
    hop_new   = upd ? {1'b0, nb_r} : lv_d.hop;
    pend_new  = is_self ? cost_r : pend_r;
    change_new = change_r || returning || upd;
    dest_word.cost = (last_r && dest_r == nb_r) ? pend_new : relaxed_cost;
    dest_word.hop  = hop_new;
  end

  // execute step: flags, pending state and result
  always_comb begin
    live_valid_nxt = live_valid_r;
    bk_valid_nxt   = bk_valid_r;
    alias_nxt      = alias_r;
    bk_init_nxt    = bk_init_r;
    pend_nxt       = pend_r;
    change_nxt     = change_r;
    need_last      = 1'b0;
    out_dest_nxt   = out_dest_r;
    out_cost_nxt   = out_cost_r;
    out_hop_nxt    = out_hop_r;
    out_ec_nxt     = out_ec_r;
    out_tc_nxt     = out_tc_r;
    if (state_r == dvtu_pkg::ST_EXEC) begin
      out_dest_nxt = dest_r;
      out_cost_nxt = dvtu_pkg::COST_UNREACH;
      out_hop_nxt  = dvtu_pkg::HOP_NONE;
      out_ec_nxt   = 1'b0;
      out_tc_nxt   = 1'b0;
      unique case (kind_r)
        dvtu_pkg::KIND_LOAD: begin
          out_dest_nxt = nb_r;
          if (nb_ok) begin
            bk_init_nxt[nb_a]    = 1'b1;
            alias_nxt[nb_a]      = 1'b1;
            live_valid_nxt[nb_a] = 1'b1;
            bk_valid_nxt[nb_a]   = 1'b1;
            out_cost_nxt = cost_r;
            out_hop_nxt  = {1'b0, nb_r};
            out_ec_nxt   = lv_n.hop != {1'b0, nb_r};
          end
        end
        dvtu_pkg::KIND_DOWN: begin
          out_dest_nxt = nb_r;
          if (nb_ok) begin
            if (bk_n.cost != dvtu_pkg::COST_UNREACH) begin
              bk_valid_nxt[nb_a] = 1'b0;
            end
            live_valid_nxt = bk_valid_nxt;
            alias_nxt      = '1;
            out_cost_nxt = bk_n.cost;
            out_hop_nxt  = bk_n.hop;
            out_ec_nxt   = lv_n.hop != bk_n.hop;
          end
        end
        dvtu_pkg::KIND_ADV: begin
          if (nb_ok && dest_ok) begin
            bk_valid_nxt[nb_a]   = 1'b1;
            live_valid_nxt[nb_a] = 1'b1;
            alias_nxt[dest_a]    = 1'b0;
            need_last    = last_r && dest_r != nb_r;
            out_cost_nxt = dest_word.cost;
            out_hop_nxt  = dest_word.hop;
            out_ec_nxt   = upd;
            out_tc_nxt   = last_r && change_new;
            pend_nxt     = last_r ? dvtu_pkg::COST_UNREACH : pend_new;
            change_nxt   = last_r ? 1'b0 : change_new;
          end
        end
        default: begin
          out_dest_nxt = dest_r;
        end
      endcase
    end else if (state_r == dvtu_pkg::ST_LAST) begin
      alias_nxt[last_addr_r] = 1'b0;
    end
  end

  // next state
  always_comb begin
    unique case (state_r)
      dvtu_pkg::ST_IDLE: state_nxt = accept ? dvtu_pkg::ST_READ : dvtu_pkg::ST_IDLE;
      dvtu_pkg::ST_READ: state_nxt = dvtu_pkg::ST_EXEC;
      dvtu_pkg::ST_EXEC: begin
        if (need_last) begin
          state_nxt = dvtu_pkg::ST_LAST;
        end else begin
          state_nxt = accept ? dvtu_pkg::ST_READ : dvtu_pkg::ST_IDLE;
        end
      end
      dvtu_pkg::ST_LAST: state_nxt = accept ? dvtu_pkg::ST_READ : dvtu_pkg::ST_IDLE;
      default:           state_nxt = dvtu_pkg::ST_IDLE;
    endcase
  end

  // state outputs: busy, memory writes, result strobe
  always_comb begin
    busy          = 1'b0;
    live_we       = 1'b0;
    live_waddr    = dest_a;
    live_wdata    = dest_word;
    bk_we         = 1'b0;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      dvtu_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      dvtu_pkg::ST_READ: begin
        busy = 1'b1;
      end
      dvtu_pkg::ST_EXEC: begin
        busy          = need_last;
        live_we       = kind_r == dvtu_pkg::KIND_ADV && nb_ok && dest_ok;
        bk_we         = kind_r == dvtu_pkg::KIND_LOAD && nb_ok;
        out_valid_nxt = !need_last;
      end
      dvtu_pkg::ST_LAST: begin
        live_we       = 1'b1;
        live_waddr    = last_addr_r;
        live_wdata    = last_word_r;
        out_valid_nxt = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dvtu_pkg::ST_IDLE;
      self_r       <= '0;
      live_valid_r <= '1;
      bk_valid_r   <= '1;
      alias_r      <= '1;
      bk_init_r    <= '0;
      pend_r       <= dvtu_pkg::COST_UNREACH;
      change_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      live_valid_r <= live_valid_nxt;
      bk_valid_r   <= bk_valid_nxt;
      alias_r      <= alias_nxt;
      bk_init_r    <= bk_init_nxt;
      pend_r       <= pend_nxt;
      change_r     <= change_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr) begin
        self_r <= pwdata[2:0];
      end
    end
  end

  // item capture, neighbor self-cost write and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      nb_r   <= in_neighbor;
      dest_r <= in_dest;
      cost_r <= in_cost[15] ? dvtu_pkg::COST_UNREACH : $unsigned(in_cost);
      last_r <= in_last;
    end
    if (state_r == dvtu_pkg::ST_EXEC) begin
      last_addr_r      <= nb_a;
      last_word_r.cost <= pend_new;
      last_word_r.hop  <= lv_n.hop;
    end
    out_dest_r <= out_dest_nxt;
    out_cost_r <= out_cost_nxt;
    out_hop_r  <= out_hop_nxt;
    out_ec_r   <= out_ec_nxt;
    out_tc_r   <= out_tc_nxt;
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && paddr[2] == dvtu_pkg::REG_SELF_INDEX;
  assign prdata = (paddr[2] == dvtu_pkg::REG_SELF_INDEX) ? {29'b0, self_r} : '0;

  assign out_valid          = out_valid_r;
  assign out_entry_dest     = out_dest_r;
  assign out_entry_cost     = $signed(out_cost_r);
  assign out_entry_next_hop = out_hop_r;
  assign out_entry_changed  = out_ec_r;
  assign out_table_changed  = out_tc_r;

  `DVTU_ASSERT_NEXT(a_accept_reads, start && !busy, state_r == dvtu_pkg::ST_READ)
  `DVTU_ASSERT_NOW(a_beat_after_work, out_valid,
                   state_r == dvtu_pkg::ST_IDLE || state_r == dvtu_pkg::ST_READ)
  `DVTU_ASSERT_NEXT(a_last_gives_beat, state_r == dvtu_pkg::ST_LAST, out_valid)
  `DVTU_ASSERT_NOW(a_bk_write_load, bk_we,
                   state_r == dvtu_pkg::ST_EXEC && kind_r == dvtu_pkg::KIND_LOAD)

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import dvtu_pkg::*;

  localparam int NODES = 8;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] SELF_ADDR = 3'(4 * REG_SELF_INDEX);
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 380;

  typedef struct {
    logic [IDX_W-1:0]         dest;
    logic signed [COST_W-1:0] cost;
    logic [HOP_W-1:0]         hop;
    logic                     entry_changed;
    logic                     table_changed;
  } route_report_t;

  // route table mirror plus the queue of reports still owed by the block
  class route_table_tracker;
    logic [IDX_W-1:0]         self_idx;
    logic signed [COST_W-1:0] live_cost[NODES];
    logic [HOP_W-1:0]         live_hop[NODES];
    bit                       live_ok[NODES];
    logic signed [COST_W-1:0] backup_cost[NODES];
    logic [HOP_W-1:0]         backup_hop[NODES];
    bit                       backup_ok[NODES];
    logic signed [COST_W-1:0] pending_self;
    bit                       change_seen;
    route_report_t            expected_reports[$];
    int                       fail_count;

    function new();
      self_idx = '0;
      for (int i = 0; i < NODES; i++) begin
        live_cost[i] = COST_UNREACH;
        live_hop[i] = HOP_NONE;
        live_ok[i] = 1'b1;
        backup_cost[i] = COST_UNREACH;
        backup_hop[i] = HOP_NONE;
        backup_ok[i] = 1'b1;
      end
      pending_self = COST_UNREACH;
      change_seen = 1'b0;
      fail_count = 0;
    endfunction

    function void set_self(logic [IDX_W-1:0] value);
      self_idx = value;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // invalid entries count as unreachable
    function int usable_cost(int i);
      return live_ok[i] ? int'(live_cost[i]) : -1;
    endfunction

    // one accepted beat: update the mirror and queue the report it produces
    function void apply_item(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] nb,
                             logic [IDX_W-1:0] dest, logic signed [COST_W-1:0] raw_cost,
                             logic last);
      route_report_t r;
      logic signed [COST_W-1:0] cost;
      logic [HOP_W-1:0] old_hop;
      int orig;
      int via;
      int sum;
      bit moved;
      cost = raw_cost[COST_W-1] ? COST_UNREACH : raw_cost;
      r.entry_changed = 1'b0;
      r.table_changed = 1'b0;
      moved = 1'b0;
      if (kind == KIND_LOAD) begin
        old_hop = live_hop[nb];
        live_cost[nb] = cost;
        live_hop[nb] = HOP_W'(nb);
        live_ok[nb] = 1'b1;
        backup_cost[nb] = cost;
        backup_hop[nb] = HOP_W'(nb);
        backup_ok[nb] = 1'b1;
        r.dest = nb;
        r.cost = live_cost[nb];
        r.hop = live_hop[nb];
        r.entry_changed = (old_hop != HOP_W'(nb));
      end else if (kind == KIND_DOWN) begin
        // a neighbor with no backup route stays valid, live is restored anyway
        old_hop = live_hop[nb];
        if (backup_cost[nb] != COST_UNREACH) backup_ok[nb] = 1'b0;
        for (int i = 0; i < NODES; i++) begin
          live_cost[i] = backup_cost[i];
          live_hop[i] = backup_hop[i];
          live_ok[i] = backup_ok[i];
        end
        r.dest = nb;
        r.cost = live_cost[nb];
        r.hop = live_hop[nb];
        r.entry_changed = (old_hop != live_hop[nb]);
      end else if (kind == KIND_ADV) begin
        // returning neighbor
        if (!backup_ok[nb]) begin
          backup_ok[nb] = 1'b1;
          live_ok[nb] = 1'b1;
          change_seen = 1'b1;
        end
        if (dest == self_idx) begin
          pending_self = cost;
        end else begin
          orig = usable_cost(dest);
          via = usable_cost(nb);
          if (via != -1 && int'(cost) != -1) begin
            sum = via + int'(cost);
            if (sum > int'(COST_MAX)) sum = int'(COST_MAX);
            if (orig == -1 || sum < orig) begin
              moved = 1'b1;
              live_cost[dest] = COST_W'(sum);
            end else if (sum == orig) begin
              // tie goes to the lower-numbered hop
              live_cost[dest] = COST_W'(sum);
              if (live_hop[dest] > HOP_W'(nb)) moved = 1'b1;
            end
          end
          if (moved) begin
            live_hop[dest] = HOP_W'(nb);
            change_seen = 1'b1;
          end
        end
        // neighbor cost taken from its advertised cost to self, or unreachable
        if (last) begin
          live_cost[nb] = pending_self;
          r.table_changed = change_seen;
          pending_self = COST_UNREACH;
          change_seen = 1'b0;
        end
        r.dest = dest;
        r.cost = live_cost[dest];
        r.hop = live_hop[dest];
        r.entry_changed = moved;
      end else begin
        r.dest = dest;
        r.cost = COST_UNREACH;
        r.hop = HOP_NONE;
      end
      expected_reports.insert(expected_reports.size(), r);
    endfunction

    function void compare_field(string name, int exp_v, int got_v);
      if (exp_v != got_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
        fail_count++;
      end
    endfunction

    function void check_report(route_report_t got);
      route_report_t exp_r;
      if (expected_reports.size() == 0) begin
        $error("result beat with no expectation waiting (dest %0d)", got.dest);
        fail_count++;
        return;
      end
      exp_r = expected_reports.pop_front();
      compare_field("entry_dest", exp_r.dest, got.dest);
      compare_field("entry_cost", int'(exp_r.cost), int'(got.cost));
      compare_field("entry_next_hop", exp_r.hop, got.hop);
      compare_field("entry_changed", exp_r.entry_changed, got.entry_changed);
      compare_field("table_changed", exp_r.table_changed, got.table_changed);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [KIND_W-1:0] in_kind;
  logic [IDX_W-1:0] in_neighbor;
  logic [IDX_W-1:0] in_dest;
  logic signed [COST_W-1:0] in_cost;
  logic in_last;
  logic out_valid;
  logic [IDX_W-1:0] out_entry_dest;
  logic signed [COST_W-1:0] out_entry_cost;
  logic [HOP_W-1:0] out_entry_next_hop;
  logic out_entry_changed;
  logic out_table_changed;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  route_table_tracker board;
  int items_sent;
  int quiet_cycles;

  distance_vector_table_update #(.NODES(NODES)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_neighbor(in_neighbor),
    .in_dest(in_dest),
    .in_cost(in_cost),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_entry_dest(out_entry_dest),
    .out_entry_cost(out_entry_cost),
    .out_entry_next_hop(out_entry_next_hop),
    .out_entry_changed(out_entry_changed),
    .out_table_changed(out_table_changed),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result beats are checked as they are accepted
  always @(posedge clk) begin
    route_report_t got;
    if (rst_n && out_valid) begin
      got.dest = out_entry_dest;
      got.cost = out_entry_cost;
      got.hop = out_entry_next_hop;
      got.entry_changed = out_entry_changed;
      got.table_changed = out_table_changed;
      board.check_report(got);
    end
  end

  // watchdog on cycles with no beat accepted on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // mostly short costs so routes relax, with unreachable and large values mixed in
  function automatic logic signed [COST_W-1:0] rand_cost();
    int p;
    p = $urandom_range(99);
    if (p < 10) return COST_UNREACH;
    if (p < 20) return COST_W'($urandom_range(32767));
    if (p < 25) return COST_W'($urandom_range(32766, 32767));
    return COST_W'($urandom_range(12));
  endfunction

  task automatic send_item(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] nb,
                           logic [IDX_W-1:0] dest, logic signed [COST_W-1:0] cost,
                           logic last);
    // random sender gaps, except over one long stretch
    while (!(items_sent >= 800 && items_sent < 1100) && $urandom_range(99) < 7) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_kind <= kind;
    in_neighbor <= nb;
    in_dest <= dest;
    in_cost <= cost;
    in_last <= last;
    do @(posedge clk); while (busy);
    board.apply_item(kind, nb, dest, cost, last);
    items_sent++;
  endtask

  // one advertisement: consecutive destinations, optionally missing its last mark
  task automatic send_advert(logic [IDX_W-1:0] nb, bit cut_short);
    int n;
    int off;
    n = $urandom_range(1, NODES);
    off = $urandom_range(NODES - 1);
    for (int k = 0; k < n; k++)
      send_item(KIND_ADV, nb, IDX_W'(off + k), rand_cost(), (k == n - 1) && !cut_short);
  endtask

  // stop issuing and let every owed report come back
  task automatic settle_block();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write followed by a readback
  task automatic write_self_index(logic [IDX_W-1:0] value);
    logic [31:0] rd;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SELF_ADDR;
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_self(value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[IDX_W-1:0] != value) begin
      $error("self_index readback mismatch: expected %0d, actual %0d", value, rd[IDX_W-1:0]);
      board.fail_count++;
    end
  endtask

  initial begin
    logic [IDX_W-1:0] self_vals[5];
    int p;
    int stop_at;
    logic [IDX_W-1:0] nb;
    board = new();
    items_sent = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_LOAD;
    in_neighbor = '0;
    in_dest = '0;
    in_cost = '0;
    in_last = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part, self index at its reset value
    send_item(KIND_LOAD, 3'd1, 3'd0, 16'sd0, 1'b0);
    send_item(KIND_LOAD, 3'd2, 3'd5, 16'sd32767, 1'b1);
    send_item(KIND_LOAD, 3'd3, 3'd7, COST_UNREACH, 1'b0);
    send_item(KIND_LOAD, 3'd7, 3'd0, 16'sd5, 1'b0);
    send_item(KIND_ADV, 3'd1, 3'd0, 16'sd0, 1'b0);
    send_item(KIND_ADV, 3'd1, 3'd4, 16'sd3, 1'b0);
    // equal cost through a lower hop
    send_item(KIND_ADV, 3'd1, 3'd2, 16'sd32767, 1'b0);
    send_item(KIND_ADV, 3'd1, 3'd5, COST_UNREACH, 1'b1);
    send_item(KIND_ADV, 3'd2, 3'd4, 16'sd0, 1'b0);
    // saturating sum
    send_item(KIND_ADV, 3'd2, 3'd6, 16'sd32767, 1'b0);
    // advertisement without a self element
    send_item(KIND_ADV, 3'd2, 3'd3, 16'sd1, 1'b1);
    send_item(KIND_DOWN, 3'd1, 3'd0, 16'sd0, 1'b0);
    // down of a neighbor with no route
    send_item(KIND_DOWN, 3'd3, 3'd2, 16'sd7, 1'b1);
    // returning neighbor
    send_item(KIND_ADV, 3'd1, 3'd4, 16'sd2, 1'b0);
    send_item(KIND_ADV, 3'd1, 3'd0, 16'sd4, 1'b1);
    send_item(KIND_UNUSED, 3'd5, 3'd6, 16'sh1234, 1'b1);
    send_item(KIND_ADV, 3'd4, 3'd5, 16'sd1, 1'b1);
    send_item(KIND_LOAD, 3'd0, 3'd3, 16'sd9, 1'b0);
    send_item(KIND_ADV, 3'd7, 3'd1, 16'sd0, 1'b1);
    send_item(KIND_DOWN, 3'd7, 3'd7, COST_UNREACH, 1'b0);
    send_item(KIND_ADV, 3'd6, 3'd7, 16'sd2, 1'b1);

    // random phases, each under its own self index
    self_vals[0] = 3'd7;
    self_vals[1] = 3'd0;
    for (int i = 2; i < 5; i++) self_vals[i] = IDX_W'($urandom_range(NODES - 1));
    for (int ph = 0; ph < 5; ph++) begin
      settle_block();
      write_self_index(self_vals[ph]);
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
        p = $urandom_range(99);
        nb = IDX_W'($urandom_range(NODES - 1));
        if (p < 58) send_advert(nb, $urandom_range(19) == 0);
        else if (p < 78) send_item(KIND_LOAD, nb, IDX_W'($urandom), rand_cost(), 1'($urandom));
        else if (p < 88) send_item(KIND_DOWN, nb, IDX_W'($urandom), rand_cost(), 1'($urandom));
        else if (p < 97)
          send_item(KIND_ADV, nb, IDX_W'($urandom), rand_cost(), 1'($urandom));
        else send_item(KIND_UNUSED, nb, IDX_W'($urandom), rand_cost(), 1'($urandom));
      end
    end

    settle_block();
    repeat (10) @(posedge clk);
    if (board.fail_count == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      if (board.pending() != 0) $error("%0d expected results never arrived", board.pending());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/dvtu_pkg.sv
hw/rtl/dvtu_ram.sv
hw/rtl/distance_vector_table_update.sv
tb/tb.sv
